FILE: sv/sqvt_pkg.sv
// ----------------------------------------------------------------------------
// sqvt_pkg: shared constants, types and sine table for the sprite quad unit
// holds field widths, register codes, divider sizing and the quarter-wave table
// ----------------------------------------------------------------------------
`default_nettype none

package sqvt_pkg;

    // table and angle sizing
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int ANGLE_STEPS      = 4096;
    localparam int ANGLE_W          = 12;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_W          = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int PHASE_PROD_W     = ANGLE_W + PHASE_W + 1;
    localparam int SINE_W           = 15;

    // configuration registers
    localparam int CFG_W       = 14;
    localparam int CFG_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] CFG_VIEWPORT_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_VIEWPORT_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_TEXTURE_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_TEXTURE_HEIGHT  = 2'd3;

    localparam logic [CFG_W-1:0] RST_VIEWPORT_WIDTH  = 14'd1280;
    localparam logic [CFG_W-1:0] RST_VIEWPORT_HEIGHT = 14'd720;
    localparam logic [CFG_W-1:0] RST_TEXTURE_WIDTH   = 14'd256;
    localparam logic [CFG_W-1:0] RST_TEXTURE_HEIGHT  = 14'd256;

    // corners
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // divider sizing
    localparam int NUM_W   = 38;
    localparam int DEN_W   = 20;
    localparam int QUO_W   = 16;
    localparam int DIV_LAT = QUO_W + 1;

    // bias multipliers that move the ndc quotient into [0, 65535]
    localparam longint NDC_BIAS_X_MUL = 24576 * 64;
    localparam longint NDC_BIAS_Y_MUL = 24575 * 64;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    typedef struct packed {
        logic [SINE_ADDR_W-1:0] sin_addr;
        logic [SINE_ADDR_W-1:0] cos_addr;
        logic                   sin_neg;
        logic                   cos_neg;
        logic signed [17:0]     cen_x;
        logic signed [17:0]     cen_y;
        logic [15:0]            dw;
        logic [15:0]            dh;
        logic [16:0]            u_near;
        logic [16:0]            u_far;
        logic [16:0]            v_near;
        logic [16:0]            v_far;
        logic [31:0]            color;
    } sqvt_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // sin(pi/2*k/depth) in Q1.14, Taylor series to x^11 in Q30
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t          tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = ((x * x2) >> 30) / 64'd6;
            sum  = $signed(x) - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            r    = (sum + 64'sd32768) >>> 16;
            if (r < 0)
            begin
                r = 0;
            end
            if (r > 16384)
            begin
                r = 16384;
            end
            tab[k] = r[SINE_W-1:0];
        end
        return tab;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

FILE: sv/sprite_quad_vertex_transform_unit.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_unit: sprite to four rotated ndc vertices
// takes a destination rectangle, angle, source rectangle and color, and
// emits four vertices with ndc position, texture coordinates and color
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  sprite   | in        | in_valid / in_stall     | dest_*, turn_angle, src_*, color
//  vertex   | out       | out_valid / out_stall   | corner_index, ndc_*, tex_*, ...
//  config   | in        | apb psel/penable/pwrite | four 14 bit size registers
//
//  one vertex output sets the rate: one corner per cycle while out_stall is low
//  from sprite accept to first vertex the path runs through 4 math stages,
//  a 17 stage divider pipe and the output register
//  after reset the SINE_TABLE_DEPTH+1 = 1025 sine table entries are filled,
//  in_stall stays high during the fill; config writes are taken as ever
//  while a vertex waits at the output, out_stall freezes the whole back pipeline;
//  the two entry queue keeps taking sprites until it is full
//
`default_nettype none

module sprite_quad_vertex_transform_unit
    import sqvt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // apb config port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready,

    // sprite items
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic signed [15:0]     dest_left,
    input  wire logic signed [15:0]     dest_top,
    input  wire logic [15:0]            dest_width,
    input  wire logic [15:0]            dest_height,
    input  wire logic [ANGLE_W-1:0]     turn_angle,
    input  wire logic [15:0]            src_left,
    input  wire logic [15:0]            src_top,
    input  wire logic [15:0]            src_width,
    input  wire logic [15:0]            src_height,
    input  wire logic [31:0]            color_rgba,

    // vertex items
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  corner_index,
    output logic signed [15:0]          ndc_x,
    output logic signed [15:0]          ndc_y,
    output logic [15:0]                 tex_u,
    output logic [15:0]                 tex_v,
    output logic [31:0]                 vertex_color,
    output logic                        last_vertex
);

    logic [CFG_W-1:0] viewport_width_reg;
    logic [CFG_W-1:0] viewport_height_reg;
    logic [CFG_W-1:0] texture_width_reg;
    logic [CFG_W-1:0] texture_height_reg;
    logic             cfg_write;
    logic [1:0]       cfg_sel;
    logic [CFG_W-1:0] cfg_rd_value;

    logic          push;
    logic          pop;
    logic          init_busy;
    sqvt_entry_t   push_entry;
    sqvt_entry_t   head_entry;
    queue_status_t q_status;

    // config registers, word addressed
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viewport_width_reg  <= RST_VIEWPORT_WIDTH;
            viewport_height_reg <= RST_VIEWPORT_HEIGHT;
            texture_width_reg   <= RST_TEXTURE_WIDTH;
            texture_height_reg  <= RST_TEXTURE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                CFG_VIEWPORT_WIDTH:  viewport_width_reg  <= pwdata[CFG_W-1:0];
                CFG_VIEWPORT_HEIGHT: viewport_height_reg <= pwdata[CFG_W-1:0];
                CFG_TEXTURE_WIDTH:   texture_width_reg   <= pwdata[CFG_W-1:0];
                CFG_TEXTURE_HEIGHT:  texture_height_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            CFG_VIEWPORT_WIDTH:  cfg_rd_value = viewport_width_reg;
            CFG_VIEWPORT_HEIGHT: cfg_rd_value = viewport_height_reg;
            CFG_TEXTURE_WIDTH:   cfg_rd_value = texture_width_reg;
            CFG_TEXTURE_HEIGHT:  cfg_rd_value = texture_height_reg;
            default:             cfg_rd_value = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(cfg_rd_value);

    // front: accept and classify sprites
    sqvt_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .dest_left   (dest_left),
        .dest_top    (dest_top),
        .dest_width  (dest_width),
        .dest_height (dest_height),
        .turn_angle  (turn_angle),
        .src_left    (src_left),
        .src_top     (src_top),
        .src_width   (src_width),
        .src_height  (src_height),
        .color_rgba  (color_rgba),
        .init_busy   (init_busy),
        .q_status    (q_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    // queue decouples sprite intake from the corner pipeline
    sqvt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    // back: four corners per sprite, rotation, ndc and texture mapping
    sqvt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .viewport_width  (viewport_width_reg),
        .viewport_height (viewport_height_reg),
        .texture_width   (texture_width_reg),
        .texture_height  (texture_height_reg),
        .head_entry      (head_entry),
        .q_status        (q_status),
        .pop             (pop),
        .init_busy       (init_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .corner_index    (corner_index),
        .ndc_x           (ndc_x),
        .ndc_y           (ndc_y),
        .tex_u           (tex_u),
        .tex_v           (tex_v),
        .vertex_color    (vertex_color),
        .last_vertex     (last_vertex)
    );

endmodule

`default_nettype wire

FILE: sv/sqvt_ram.sv
// ----------------------------------------------------------------------------
// sqvt_ram: generic single write, dual read memory
// one write port, two read ports with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sqvt_front.sv
// ----------------------------------------------------------------------------
// sqvt_front: input side of the sprite quad unit
// accepts sprites, works out table addresses, centre and texture edges
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_front
    import sqvt_pkg::*;
(
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [15:0]   dest_left,
    input  wire logic signed [15:0]   dest_top,
    input  wire logic [15:0]          dest_width,
    input  wire logic [15:0]          dest_height,
    input  wire logic [ANGLE_W-1:0]   turn_angle,
    input  wire logic [15:0]          src_left,
    input  wire logic [15:0]          src_top,
    input  wire logic [15:0]          src_width,
    input  wire logic [15:0]          src_height,
    input  wire logic [31:0]          color_rgba,
    input  wire logic                 init_busy,
    input  wire queue_status_t        q_status,
    output logic                      push,
    output sqvt_entry_t               push_entry
);

    logic [PHASE_PROD_W-1:0] phase_prod;
    logic [PHASE_W-1:0]      phase;
    logic [1:0]              quad;
    logic [SINE_ADDR_W-1:0]  idx;
    logic [SINE_ADDR_W-1:0]  idx_mirror;

    assign in_stall = q_status.full || init_busy;
    assign push     = in_valid && !in_stall;

    // binary angle to table phase, then quadrant fold
    assign phase_prod = PHASE_PROD_W'((PHASE_PROD_W'(turn_angle)
                                       * PHASE_PROD_W'(4 * SINE_TABLE_DEPTH))
                                      / ANGLE_STEPS);
    assign phase      = phase_prod[PHASE_W-1:0];
    assign quad       = phase[PHASE_W-1 -: 2];
    assign idx        = SINE_ADDR_W'(phase[SINE_IDX_W-1:0]);
    assign idx_mirror = SINE_ADDR_W'(SINE_TABLE_DEPTH) - idx;

    always_comb
    begin
        push_entry.sin_addr = quad[0] ? idx_mirror : idx;
        push_entry.cos_addr = quad[0] ? idx : idx_mirror;
        push_entry.sin_neg  = quad[1];
        push_entry.cos_neg  = quad[1] ^ quad[0];
        push_entry.cen_x    = (18'(dest_left) <<< 1) + $signed({2'b00, dest_width});
        push_entry.cen_y    = (18'(dest_top) <<< 1) + $signed({2'b00, dest_height});
        push_entry.dw       = dest_width;
        push_entry.dh       = dest_height;
        push_entry.u_near   = {1'b0, src_left};
        push_entry.u_far    = 17'(src_left) + 17'(src_width);
        push_entry.v_near   = {1'b0, src_top};
        push_entry.v_far    = 17'(src_top) + 17'(src_height);
        push_entry.color    = color_rgba;
    end

endmodule

`default_nettype wire

FILE: sv/sqvt_queue.sv
// ----------------------------------------------------------------------------
// sqvt_queue: short queue between front and back
// holds classified sprites until the back end has issued all four corners
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_queue
    import sqvt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sqvt_entry_t   push_entry,
    input  wire logic          pop,
    output sqvt_entry_t        head_entry,
    output queue_status_t      q_status
);

    sqvt_entry_t              store_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;

    assign head_entry     = store_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sqvt_div.sv
// ----------------------------------------------------------------------------
// sqvt_div: pipelined restoring divider with range flags
// one quotient bit per stage, flags a negative or too large numerator
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_div
    import sqvt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]        den,
    output logic [QUO_W-1:0]             quo,
    output logic                         under,
    output logic                         over
);

    localparam int REM_W = DEN_W + QUO_W + 1;

    logic [REM_W-1:0] rem_reg   [0:QUO_W];
    logic [DEN_W-1:0] den_reg   [0:QUO_W];
    logic [QUO_W-1:0] quo_reg   [0:QUO_W];
    logic             under_reg [0:QUO_W];
    logic             over_reg  [0:QUO_W];
    logic [REM_W:0]   trial     [1:QUO_W];
    logic [QUO_W-1:0] quo_next  [1:QUO_W];

    // trial subtract of the shifted divisor in every stage
    always_comb
    begin
        for (int j = 1; j <= QUO_W; j++)
        begin
            trial[j]    = {1'b0, rem_reg[j-1]} - ((REM_W + 1)'(den_reg[j-1]) << (QUO_W - j));
            quo_next[j] = quo_reg[j-1];
            quo_next[j][QUO_W - j] = ~trial[j][REM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            under_reg[0] <= num[NUM_W-1];
            over_reg[0]  <= !num[NUM_W-1]
                            && (num[NUM_W-2:0] >= ((NUM_W - 1)'(den) << QUO_W));
            rem_reg[0]   <= num[REM_W-1:0];
            den_reg[0]   <= den;
            quo_reg[0]   <= '0;
            for (int j = 1; j <= QUO_W; j++)
            begin
                rem_reg[j]   <= trial[j][REM_W] ? rem_reg[j-1] : trial[j][REM_W-1:0];
                den_reg[j]   <= den_reg[j-1];
                quo_reg[j]   <= quo_next[j];
                under_reg[j] <= under_reg[j-1];
                over_reg[j]  <= over_reg[j-1];
            end
        end
    end

    assign quo   = quo_reg[QUO_W];
    assign under = under_reg[QUO_W];
    assign over  = over_reg[QUO_W];

endmodule

`default_nettype wire

FILE: sv/sqvt_back.sv
// ----------------------------------------------------------------------------
// sqvt_back: corner pipeline of the sprite quad unit
// rotates four corners per sprite, maps to ndc and texture space, saturates
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_back
    import sqvt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CFG_W-1:0]   viewport_width,
    input  wire logic [CFG_W-1:0]   viewport_height,
    input  wire logic [CFG_W-1:0]   texture_width,
    input  wire logic [CFG_W-1:0]   texture_height,
    input  wire sqvt_entry_t        head_entry,
    input  wire queue_status_t      q_status,
    output logic                    pop,
    output logic                    init_busy,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              corner_index,
    output logic signed [15:0]      ndc_x,
    output logic signed [15:0]      ndc_y,
    output logic [15:0]             tex_u,
    output logic [15:0]             tex_v,
    output logic [31:0]             vertex_color,
    output logic                    last_vertex
);

    // sine table fill after reset
    logic                   init_busy_reg;
    logic [SINE_ADDR_W-1:0] init_cnt_reg;
    logic [SINE_W-1:0]      sin_raw;
    logic [SINE_W-1:0]      cos_raw;

    logic       adv;
    logic       issue;
    logic [1:0] corner_reg;

    // effective register values, zero read as one
    logic [CFG_W-1:0]        eff_vw;
    logic [CFG_W-1:0]        eff_vh;
    logic [CFG_W-1:0]        eff_tw;
    logic [CFG_W-1:0]        eff_th;
    logic [DEN_W-1:0]        den_x_reg;
    logic [DEN_W-1:0]        den_y_reg;
    logic [DEN_W-1:0]        den_u_reg;
    logic [DEN_W-1:0]        den_v_reg;
    logic signed [NUM_W-1:0] bias_x_reg;
    logic signed [NUM_W-1:0] bias_y_reg;
    logic [CFG_W-1:0]        bias_u_reg;
    logic [CFG_W-1:0]        bias_v_reg;

    // stage 1: table read in flight
    logic               s1_valid_reg;
    logic [1:0]         s1_k_reg;
    logic               s1_sin_neg_reg;
    logic               s1_cos_neg_reg;
    logic signed [17:0] s1_cen_x_reg;
    logic signed [17:0] s1_cen_y_reg;
    logic signed [16:0] s1_ox_reg;
    logic signed [16:0] s1_oy_reg;
    logic [16:0]        s1_u_edge_reg;
    logic [16:0]        s1_v_edge_reg;
    logic [31:0]        s1_color_reg;
    logic signed [15:0] s1_sval;
    logic signed [15:0] s1_cval;

    // stage 2: products
    logic               s2_valid_reg;
    logic [1:0]         s2_k_reg;
    logic signed [17:0] s2_cen_x_reg;
    logic signed [17:0] s2_cen_y_reg;
    logic signed [32:0] s2_cox_reg;
    logic signed [32:0] s2_soy_reg;
    logic signed [32:0] s2_sox_reg;
    logic signed [32:0] s2_coy_reg;
    logic [16:0]        s2_u_edge_reg;
    logic [16:0]        s2_v_edge_reg;
    logic [31:0]        s2_color_reg;

    // stage 3: partial sums
    logic                    s3_valid_reg;
    logic [1:0]              s3_k_reg;
    logic signed [33:0]      s3_diff_x_reg;
    logic signed [33:0]      s3_diff_y_reg;
    logic signed [NUM_W-1:0] s3_base_x_reg;
    logic signed [NUM_W-1:0] s3_base_y_reg;
    logic [28:0]             s3_num_u_reg;
    logic [28:0]             s3_num_v_reg;
    logic [31:0]             s3_color_reg;

    // stage 4: divider numerators
    logic                    s4_valid_reg;
    logic [1:0]              s4_k_reg;
    logic signed [NUM_W-1:0] s4_num_x_reg;
    logic signed [NUM_W-1:0] s4_num_y_reg;
    logic [28:0]             s4_num_u_reg;
    logic [28:0]             s4_num_v_reg;
    logic [31:0]             s4_color_reg;

    // tags that ride beside the dividers
    logic        tag_valid_reg [0:DIV_LAT-1];
    logic [1:0]  tag_k_reg     [0:DIV_LAT-1];
    logic [31:0] tag_color_reg [0:DIV_LAT-1];

    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic [QUO_W-1:0] qu;
    logic [QUO_W-1:0] qv;
    logic             ux;
    logic             uy;
    logic             uu;
    logic             uv;
    logic             ox_f;
    logic             oy_f;
    logic             ou_f;
    logic             ov_f;

    logic               out_valid_reg;
    logic [1:0]         out_corner_reg;
    logic signed [15:0] out_ndc_x_reg;
    logic signed [15:0] out_ndc_y_reg;
    logic [15:0]        out_tex_u_reg;
    logic [15:0]        out_tex_v_reg;
    logic [31:0]        out_color_reg;
    logic               out_last_reg;
    logic signed [15:0] ndc_x_next;
    logic signed [15:0] ndc_y_next;
    logic [15:0]        tex_u_next;
    logic [15:0]        tex_v_next;

    assign init_busy = init_busy_reg;
    assign adv       = !out_valid_reg || !out_stall;
    assign issue     = adv && !q_status.empty && !init_busy_reg;
    assign pop       = issue && (corner_reg == CORNER_BR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
        end
        else if (init_busy_reg)
        begin
            if (init_cnt_reg == SINE_ADDR_W'(SINE_TABLE_DEPTH))
            begin
                init_busy_reg <= 1'b0;
            end
            else
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
        end
    end

    sqvt_ram #(
        .WIDTH (SINE_W),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_sine_ram (
        .clk       (clk),
        .wr_en     (init_busy_reg),
        .wr_addr   (init_cnt_reg),
        .wr_data   (SINE_ROM[init_cnt_reg]),
        .rd_en     (adv),
        .rd_addr_a (head_entry.sin_addr),
        .rd_addr_b (head_entry.cos_addr),
        .rd_data_a (sin_raw),
        .rd_data_b (cos_raw)
    );

    assign eff_vw = (viewport_width  == '0) ? CFG_W'(1) : viewport_width;
    assign eff_vh = (viewport_height == '0) ? CFG_W'(1) : viewport_height;
    assign eff_tw = (texture_width   == '0) ? CFG_W'(1) : texture_width;
    assign eff_th = (texture_height  == '0) ? CFG_W'(1) : texture_height;

    always_ff @(posedge clk)
    begin
        den_x_reg  <= DEN_W'(eff_vw) << 6;
        den_y_reg  <= DEN_W'(eff_vh) << 6;
        den_u_reg  <= DEN_W'(eff_tw) << 1;
        den_v_reg  <= DEN_W'(eff_th) << 1;
        bias_x_reg <= $signed((NUM_W'(eff_vw) << 5) + NUM_W'(eff_vw) * NUM_W'(NDC_BIAS_X_MUL));
        bias_y_reg <= $signed((NUM_W'(eff_vh) << 5) + NUM_W'(eff_vh) * NUM_W'(NDC_BIAS_Y_MUL));
        bias_u_reg <= eff_tw;
        bias_v_reg <= eff_th;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_reg    <= CORNER_TL;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                tag_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            if (issue)
            begin
                corner_reg <= corner_reg + 1'b1;
            end
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            tag_valid_reg[0] <= s4_valid_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                tag_valid_reg[i] <= tag_valid_reg[i-1];
            end
            out_valid_reg <= tag_valid_reg[DIV_LAT-1];
        end
    end

    assign s1_sval = s1_sin_neg_reg ? -$signed({1'b0, sin_raw}) : $signed({1'b0, sin_raw});
    assign s1_cval = s1_cos_neg_reg ? -$signed({1'b0, cos_raw}) : $signed({1'b0, cos_raw});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1
            s1_k_reg       <= corner_reg;
            s1_sin_neg_reg <= head_entry.sin_neg;
            s1_cos_neg_reg <= head_entry.cos_neg;
            s1_cen_x_reg   <= head_entry.cen_x;
            s1_cen_y_reg   <= head_entry.cen_y;
            s1_ox_reg      <= corner_reg[0] ? $signed({1'b0, head_entry.dw})
                                            : -$signed({1'b0, head_entry.dw});
            s1_oy_reg      <= corner_reg[1] ? $signed({1'b0, head_entry.dh})
                                            : -$signed({1'b0, head_entry.dh});
            s1_u_edge_reg  <= corner_reg[0] ? head_entry.u_far : head_entry.u_near;
            s1_v_edge_reg  <= corner_reg[1] ? head_entry.v_far : head_entry.v_near;
            s1_color_reg   <= head_entry.color;

            // stage 2: rotation products
            s2_k_reg      <= s1_k_reg;
            s2_cen_x_reg  <= s1_cen_x_reg;
            s2_cen_y_reg  <= s1_cen_y_reg;
            s2_cox_reg    <= s1_cval * s1_ox_reg;
            s2_soy_reg    <= s1_sval * s1_oy_reg;
            s2_sox_reg    <= s1_sval * s1_ox_reg;
            s2_coy_reg    <= s1_cval * s1_oy_reg;
            s2_u_edge_reg <= s1_u_edge_reg;
            s2_v_edge_reg <= s1_v_edge_reg;
            s2_color_reg  <= s1_color_reg;

            // stage 3: rotated offsets, biased centre, texture numerators
            s3_k_reg      <= s2_k_reg;
            s3_diff_x_reg <= 34'(s2_cox_reg) - 34'(s2_soy_reg);
            s3_diff_y_reg <= 34'(s2_sox_reg) + 34'(s2_coy_reg);
            s3_base_x_reg <= (NUM_W'(s2_cen_x_reg) <<< 15) + bias_x_reg;
            s3_base_y_reg <= (NUM_W'(s2_cen_y_reg) <<< 15) + bias_y_reg;
            s3_num_u_reg  <= (29'(s2_u_edge_reg) << 11) + 29'(bias_u_reg);
            s3_num_v_reg  <= (29'(s2_v_edge_reg) << 11) + 29'(bias_v_reg);
            s3_color_reg  <= s2_color_reg;

            // stage 4: ndc numerators
            s4_k_reg     <= s3_k_reg;
            s4_num_x_reg <= s3_base_x_reg + (NUM_W'(s3_diff_x_reg) <<< 1);
            s4_num_y_reg <= s3_base_y_reg + (NUM_W'(s3_diff_y_reg) <<< 1);
            s4_num_u_reg <= s3_num_u_reg;
            s4_num_v_reg <= s3_num_v_reg;
            s4_color_reg <= s3_color_reg;

            tag_k_reg[0]     <= s4_k_reg;
            tag_color_reg[0] <= s4_color_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                tag_k_reg[i]     <= tag_k_reg[i-1];
                tag_color_reg[i] <= tag_color_reg[i-1];
            end

            out_corner_reg <= tag_k_reg[DIV_LAT-1];
            out_color_reg  <= tag_color_reg[DIV_LAT-1];
            out_last_reg   <= (tag_k_reg[DIV_LAT-1] == CORNER_BR);
            out_ndc_x_reg  <= ndc_x_next;
            out_ndc_y_reg  <= ndc_y_next;
            out_tex_u_reg  <= tex_u_next;
            out_tex_v_reg  <= tex_v_next;
        end
    end

    sqvt_div u_div_x (
        .clk (clk), .en (adv), .num (s4_num_x_reg), .den (den_x_reg),
        .quo (qx), .under (ux), .over (ox_f)
    );

    sqvt_div u_div_y (
        .clk (clk), .en (adv), .num (s4_num_y_reg), .den (den_y_reg),
        .quo (qy), .under (uy), .over (oy_f)
    );

    sqvt_div u_div_u (
        .clk (clk), .en (adv), .num ($signed({9'b0, s4_num_u_reg})), .den (den_u_reg),
        .quo (qu), .under (uu), .over (ou_f)
    );

    sqvt_div u_div_v (
        .clk (clk), .en (adv), .num ($signed({9'b0, s4_num_v_reg})), .den (den_v_reg),
        .quo (qv), .under (uv), .over (ov_f)
    );

    // quotients are offset into [0, 65535], flags mark saturation
    always_comb
    begin
        if (ux)
        begin
            ndc_x_next = 16'sh8000;
        end
        else if (ox_f)
        begin
            ndc_x_next = 16'sh7FFF;
        end
        else
        begin
            ndc_x_next = $signed({~qx[QUO_W-1], qx[QUO_W-2:0]});
        end

        if (uy)
        begin
            ndc_y_next = 16'sh7FFF;
        end
        else if (oy_f)
        begin
            ndc_y_next = 16'sh8000;
        end
        else
        begin
            ndc_y_next = $signed(16'h7FFF - qy);
        end

        tex_u_next = (ou_f || uu) ? 16'hFFFF : qu;
        tex_v_next = (ov_f || uv) ? 16'hFFFF : qv;
    end

    assign out_valid    = out_valid_reg;
    assign corner_index = out_corner_reg;
    assign ndc_x        = out_ndc_x_reg;
    assign ndc_y        = out_ndc_y_reg;
    assign tex_u        = out_tex_u_reg;
    assign tex_v        = out_tex_v_reg;
    assign vertex_color = out_color_reg;
    assign last_vertex  = out_last_reg;

endmodule

`default_nettype wire

FILE: sv/sqvt_checker.sv
// ----------------------------------------------------------------------------
// sqvt_checker: port level checks for the sprite quad unit
// watches the vertex channel, config port and reset behavior
// ----------------------------------------------------------------------------
`default_nettype none

module sqvt_checker
    import sqvt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [1:0]        corner_index,
    input wire logic signed [15:0] ndc_x,
    input wire logic              last_vertex,
    input wire logic              pready
);

    // marker only on the bottom-right corner
    a_last_on_br: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_vertex == (corner_index == CORNER_BR)))
        else $error("last_vertex does not match corner_index");

    // a stalled vertex holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(corner_index) && $stable(ndc_x))
        else $error("stalled vertex changed");

    // input is stalled at reset release, as the table fill begins
    a_stall_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> in_stall)
        else $error("sprite input open during table fill");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind sprite_quad_vertex_transform_unit sqvt_checker u_sqvt_checker (.*);

`default_nettype wire

FILE: dv/sprite_quad_vertex_transform_unit_test.sv
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_unit_test: self-checking bench for the sprite unit
// drives sprites through directed and random phases under several idle
// patterns, predicts the four vertices of each sprite and checks them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_quad_vertex_transform_unit_test;
    import sqvt_pkg::*;

    // one input sprite
    typedef struct packed {
        logic signed [15:0] dl;
        logic signed [15:0] dt;
        logic [15:0]        dw;
        logic [15:0]        dh;
        logic [11:0]        ang;
        logic [15:0]        sl;
        logic [15:0]        st;
        logic [15:0]        sw;
        logic [15:0]        sh;
        logic [31:0]        col;
    } sprite_t;

    // one output vertex
    typedef struct packed {
        logic [1:0]         corner;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        col;
        logic               last;
    } vertex_t;

    // directed row: sprite plus optional typed-in first vertex
    typedef struct {
        sprite_t spr;
        bit      has_tl;
        vertex_t tl;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic in_valid;
    logic in_stall;
    sprite_t drv;
    logic out_valid;
    logic out_stall;
    logic [1:0] corner_index;
    logic signed [15:0] ndc_x, ndc_y;
    logic [15:0] tex_u, tex_v;
    logic [31:0] vertex_color;
    logic last_vertex;

    sprite_quad_vertex_transform_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .dest_left(drv.dl), .dest_top(drv.dt), .dest_width(drv.dw),
        .dest_height(drv.dh), .turn_angle(drv.ang), .src_left(drv.sl),
        .src_top(drv.st), .src_width(drv.sw), .src_height(drv.sh),
        .color_rgba(drv.col),
        .out_valid(out_valid), .out_stall(out_stall),
        .corner_index(corner_index), .ndc_x(ndc_x), .ndc_y(ndc_y),
        .tex_u(tex_u), .tex_v(tex_v), .vertex_color(vertex_color),
        .last_vertex(last_vertex)
    );

    // own copy of the configuration
    logic [13:0] vp_w, vp_h, tx_w, tx_h;
    int unsigned quarter_sine [0:SINE_TABLE_DEPTH];

    vertex_t expected_vertices[$];
    int errors;
    int vertices_seen;
    int sprites_sent;
    int send_idle_pct;
    int recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // watchdog, far above the slowest legal run
    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // quarter-wave table from a Q30 taylor series, rounded to Q14
    function automatic void fill_quarter_sine();
        longint unsigned x, x2, term;
        longint s, r;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x  = (64'd1686629713 * longint'(k)) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            s = longint'(x);
            for (int n = 1; n <= 9; n += 2)
            begin
                term = (term * x2) >> 30;
                term = term / ((n + 1) * (n + 2));
                if ((((n + 1) / 2) & 1) != 0)
                    s = s - longint'(term);
                else
                    s = s + longint'(term);
            end
            r = (s + 32768) / 65536;
            if (r < 0) r = 0;
            if (r > 16384) r = 16384;
            quarter_sine[k] = 32'(r);
        end
    endfunction

    function automatic longint sine_of_phase(longint unsigned p);
        longint unsigned q, i;
        longint val;
        p = p % (4 * SINE_TABLE_DEPTH);
        q = p / SINE_TABLE_DEPTH;
        i = p % SINE_TABLE_DEPTH;
        val = q[0] ? quarter_sine[SINE_TABLE_DEPTH - i] : quarter_sine[i];
        return q[1] ? -val : val;
    endfunction

    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [15:0] clamp_s16(longint val);
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
        return val[15:0];
    endfunction

    function automatic logic [15:0] texel_coord(longint unsigned edge_q4, longint unsigned sz);
        longint unsigned t;
        t = (edge_q4 * 2048 + sz) / (2 * sz);
        return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    // push the four vertices a sprite should produce
    task automatic predict_quad(input sprite_t s);
        longint vw, vh, tw, th, dw, dh, sn, cs, cx, cy, ox, oy, px, py;
        longint unsigned p;
        logic [15:0] u[2], v[2];
        vertex_t vx;
        vw = (vp_w == 0) ? 1 : vp_w;
        vh = (vp_h == 0) ? 1 : vp_h;
        tw = (tx_w == 0) ? 1 : tx_w;
        th = (tx_h == 0) ? 1 : tx_h;
        dw = s.dw;
        dh = s.dh;
        p  = (longint'(s.ang % ANGLE_STEPS) * 4 * SINE_TABLE_DEPTH) / ANGLE_STEPS;
        sn = sine_of_phase(p);
        cs = sine_of_phase(p + SINE_TABLE_DEPTH);
        cx = (2 * longint'(s.dl) + dw) * 16384;
        cy = (2 * longint'(s.dt) + dh) * 16384;
        u[0] = texel_coord(s.sl, tw);
        u[1] = texel_coord(longint'(s.sl) + s.sw, tw);
        v[0] = texel_coord(s.st, th);
        v[1] = texel_coord(longint'(s.st) + s.sh, th);
        for (int k = 0; k < 4; k++)
        begin
            ox = k[0] ? dw : -dw;
            oy = k[1] ? dh : -dh;
            px = cx + cs * ox - sn * oy;
            py = cy + sn * ox + cs * oy;
            vx.corner = k[1:0];
            vx.nx = clamp_s16(floor_quot(2 * px + 32 * vw, 64 * vw) - 8192);
            vx.ny = clamp_s16(8192 - floor_quot(2 * py + 32 * vh, 64 * vh));
            vx.u = u[k[0]];
            vx.v = v[k[1]];
            vx.col = s.col;
            vx.last = (k == 3);
            expected_vertices.push_back(vx);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch on vertex %0d: %s got %0d want %0d", vertices_seen, what, got, want);
    endtask

    // output side: random stall and field-by-field compare
    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_vertices.size() == 0)
                begin
                    report_mismatch("unexpected vertex", corner_index, -1);
                end
                else
                begin
                    w = expected_vertices.pop_front();
                    if (corner_index !== w.corner)
                        report_mismatch("corner_index", corner_index, w.corner);
                    if (ndc_x !== w.nx) report_mismatch("ndc_x", ndc_x, w.nx);
                    if (ndc_y !== w.ny) report_mismatch("ndc_y", ndc_y, w.ny);
                    if (tex_u !== w.u) report_mismatch("tex_u", tex_u, w.u);
                    if (tex_v !== w.v) report_mismatch("tex_v", tex_v, w.v);
                    if (vertex_color !== w.col)
                        report_mismatch("vertex_color", vertex_color, w.col);
                    if (last_vertex !== w.last)
                        report_mismatch("last_vertex", last_vertex, w.last);
                end
                vertices_seen++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // register write: setup cycle then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 2;
        pwdata  <= {18'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_VIEWPORT_WIDTH:  vp_w = val;
            CFG_VIEWPORT_HEIGHT: vp_h = val;
            CFG_TEXTURE_WIDTH:   tx_w = val;
            default:             tx_h = val;
        endcase
    endtask

    task automatic write_sizes(input logic [13:0] a, b, c, d);
        write_reg(CFG_VIEWPORT_WIDTH, a);
        write_reg(CFG_VIEWPORT_HEIGHT, b);
        write_reg(CFG_TEXTURE_WIDTH, c);
        write_reg(CFG_TEXTURE_HEIGHT, d);
    endtask

    // hold one sprite until accepted; valid stays high between back-to-back sprites
    task automatic send_sprite(input sprite_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drv      <= s;
        predict_quad(s);
        do
            @(posedge clk);
        while (in_stall);
        sprites_sent++;
    endtask

    task automatic drain_vertices();
        while (expected_vertices.size() != 0)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b0;
        repeat (40) @(posedge clk);
    endtask

    function automatic sprite_t random_sprite();
        sprite_t s;
        s = $bits(sprite_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        // mostly modest rectangles so ndc lands in range, sometimes extremes
        if ($urandom_range(3) != 0)
        begin
            s.dl = $signed(16'($urandom_range(0, 8000))) - 16'sd2000;
            s.dt = $signed(16'($urandom_range(0, 8000))) - 16'sd2000;
            s.dw = 16'($urandom_range(0, 4000));
            s.dh = 16'($urandom_range(0, 4000));
            s.sl = 16'($urandom_range(0, 4000));
            s.st = 16'($urandom_range(0, 4000));
            s.sw = 16'($urandom_range(0, 4000));
            s.sh = 16'($urandom_range(0, 4000));
        end
        return s;
    endfunction

    row_t directed_rows[$];

    task automatic add_row(input sprite_t s, input bit has_tl, input vertex_t tl);
        row_t r;
        r.spr = s;
        r.has_tl = has_tl;
        r.tl = tl;
        directed_rows.push_back(r);
    endtask

    initial
    begin
        sprite_t s;
        vertex_t tl;
        int phase_items;
        errors = 0;
        vertices_seen = 0;
        sprites_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        vp_w = RST_VIEWPORT_WIDTH;
        vp_h = RST_VIEWPORT_HEIGHT;
        tx_w = RST_TEXTURE_WIDTH;
        tx_h = RST_TEXTURE_HEIGHT;
        fill_quarter_sine();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; zero-size sprite at the origin reads off directly
        s = '0;
        tl = '{corner: CORNER_TL, nx: -16'sd8192, ny: 16'sd8192, u: 16'd0, v: 16'd0,
               col: 32'h0, last: 1'b0};
        add_row(s, 1'b1, tl);
        s.col = 32'hFFFF_FFFF;
        tl.col = 32'hFFFF_FFFF;
        add_row(s, 1'b1, tl);
        // far corner saturates: huge positive position and texture edges
        s = '{dl: 16'sh7FFF, dt: 16'sh7FFF, dw: 16'hFFFF, dh: 16'hFFFF, ang: 12'd0,
              sl: 16'hFFFF, st: 16'hFFFF, sw: 16'hFFFF, sh: 16'hFFFF, col: 32'hA5A5_5A5A};
        add_row(s, 1'b0, tl);
        s.dl = -16'sd32768;
        s.dt = -16'sd32768;
        s.ang = 12'hFFF;
        add_row(s, 1'b0, tl);
        for (int a = 0; a < 4096; a += 512)
        begin
            s = '{dl: 16'sd1600, dt: 16'sd1600, dw: 16'd3200, dh: 16'd1600, ang: a[11:0],
                  sl: 16'd100, st: 16'd200, sw: 16'd1600, sh: 16'd800, col: a};
            add_row(s, 1'b0, tl);
            s.ang = a[11:0] + 12'd1;
            add_row(s, 1'b0, tl);
        end
        for (int i = 0; i < 5; i++)
        begin
            add_row(random_sprite(), 1'b0, tl);
        end

        foreach (directed_rows[i])
        begin
            send_sprite(directed_rows[i].spr);
            if (directed_rows[i].has_tl)
                expected_vertices[expected_vertices.size() - 4] = directed_rows[i].tl;
        end
        drain_vertices();

        // random phases across sizes, idle patterns and register extremes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: write_sizes(14'd1, 14'd1, 14'd1, 14'd1);
                1: write_sizes(14'd0, 14'd0, 14'd0, 14'd0);
                2: write_sizes(14'd8192, 14'd8192, 14'd8192, 14'd8192);
                3: write_sizes(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
                default: write_sizes(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                                     14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)));
            endcase
            send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 21 : 59) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 21 : 59) : 0;
            phase_items = 28;
            for (int i = 0; i < phase_items; i++)
            begin
                send_sprite(random_sprite());
            end
            drain_vertices();
        end

        $display("ran %0d sprites, checked %0d vertices over 8 register settings",
                 sprites_sent, vertices_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sprite_quad_vertex_transform_unit.f
sv/sqvt_pkg.sv
sv/sqvt_ram.sv
sv/sqvt_front.sv
sv/sqvt_queue.sv
sv/sqvt_div.sv
sv/sqvt_back.sv
sv/sprite_quad_vertex_transform_unit.sv
sv/sqvt_checker.sv
dv/sprite_quad_vertex_transform_unit_test.sv
